/* sv/twdp_pkg.sv */
// types and constants shared by the two-way depth-preferred hash table
package twdp_pkg;

  localparam int KEY_W   = 64;
  localparam int TAG_W   = 32;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 16;
  localparam int BOUND_W = 2;
  localparam int OP_W    = 2;
  localparam int SLOTS   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic signed [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0]        bound;
  } slot_t;

  typedef slot_t [SLOTS-1:0] row_t;

  typedef struct packed {
    logic                      hit;
    logic [MOVE_W-1:0]         found_move;
    logic signed [SCORE_W-1:0] found_score;
    logic signed [DEPTH_W-1:0] found_depth;
    logic [BOUND_W-1:0]        found_bound;
  } result_t;

endpackage

/* sv/twdp_if.sv */
// request and response channel interfaces of the hash table
interface twdp_in_if;
  logic                                valid;
  logic                                ready;
  logic [twdp_pkg::OP_W-1:0]           opcode;
  logic [twdp_pkg::KEY_W-1:0]          key;
  logic [twdp_pkg::MOVE_W-1:0]         move;
  logic signed [twdp_pkg::SCORE_W-1:0] score;
  logic signed [twdp_pkg::DEPTH_W-1:0] search_depth;
  logic [twdp_pkg::BOUND_W-1:0]        bound_kind;

  modport source (output valid, opcode, key, move, score, search_depth, bound_kind,
                  input ready);
  modport sink (input valid, opcode, key, move, score, search_depth, bound_kind,
                output ready);
endinterface

interface twdp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [twdp_pkg::MOVE_W-1:0]         found_move;
  logic signed [twdp_pkg::SCORE_W-1:0] found_score;
  logic signed [twdp_pkg::DEPTH_W-1:0] found_depth;
  logic [twdp_pkg::BOUND_W-1:0]        found_bound;

  modport source (output valid, hit, found_move, found_score, found_depth, found_bound,
                  input ready);
  modport sink (input valid, hit, found_move, found_score, found_depth, found_bound,
                output ready);
endinterface

/* sv/twdp_ram.sv */
// cluster row memory, one write and one registered read port
module twdp_ram #(
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output twdp_pkg::row_t    rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  twdp_pkg::row_t    wr_data
);
  import twdp_pkg::*;

  row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/two_way_depth_preferred_hash_table_unit.sv */
// Hash table of CLUSTER_COUNT clusters with two slots each, held as one row per cluster
// in a single-port-read, single-port-write memory. The cluster is the key's low bits,
// the tag its upper 32 bits. A probe or a store reads the row on acceptance, then in the
// LOOK state compares and, for a store, writes the row back; the next item is taken
// after that, once the last result is taken. A clear op walks the memory one row per
// cycle and answers its item with the last row. After reset the same clearing pass
// runs before the first item is accepted. Every item gives one result item.
module two_way_depth_preferred_hash_table_unit #(
  parameter int CLUSTER_COUNT = 1024
) (
  input logic      clk,
  input logic      rst,
  twdp_in_if.sink  req,
  twdp_out_if.source rsp
);
  import twdp_pkg::*;

  localparam int IDX_W = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLUSTER_COUNT - 1);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                     state;
  logic [IDX_W-1:0]           sweep_idx;
  logic                       sweep_reply;
  logic                       out_valid;
  result_t                    res;

  opcode_t                    op_q;
  logic [TAG_W-1:0]           tag_q;
  logic [IDX_W-1:0]           idx_q;
  logic [MOVE_W-1:0]          move_q;
  logic signed [SCORE_W-1:0]  score_q;
  logic signed [DEPTH_W-1:0]  depth_q;
  logic [BOUND_W-1:0]         bound_q;

  logic                       accept;
  logic [IDX_W-1:0]           req_idx;
  logic                       rd_en;
  row_t                       rd_data;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  row_t                       wr_data;
  row_t                       row_next;
  slot_t                      new_slot;
  logic                       hit0;
  logic                       hit1;
  logic                       take0;
  result_t                    look_res;

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign req_idx   = (CLUSTER_COUNT > 1) ? req.key[IDX_W-1:0] : '0;
  assign rd_en     = accept;

  assign rsp.valid       = out_valid;
  assign rsp.hit         = res.hit;
  assign rsp.found_move  = res.found_move;
  assign rsp.found_score = res.found_score;
  assign rsp.found_depth = res.found_depth;
  assign rsp.found_bound = res.found_bound;

  always_comb begin
    hit0 = (rd_data[0].bound != '0) && (rd_data[0].tag == tag_q);
    hit1 = (rd_data[1].bound != '0) && (rd_data[1].tag == tag_q);
    take0 = (rd_data[0].bound == '0) || (rd_data[0].tag == tag_q)
         || (depth_q >= rd_data[0].depth);

    new_slot.tag   = tag_q;
    new_slot.move  = move_q;
    new_slot.score = score_q;
    new_slot.depth = depth_q;
    new_slot.bound = bound_q;

    row_next = rd_data;
    if (take0) begin
      row_next[0] = new_slot;
    end else begin
      row_next[1] = new_slot;
    end

    look_res = '0;
    if (op_q == OP_PROBE) begin
      priority if (hit0) begin
        look_res.hit         = 1'b1;
        look_res.found_move  = rd_data[0].move;
        look_res.found_score = rd_data[0].score;
        look_res.found_depth = rd_data[0].depth;
        look_res.found_bound = rd_data[0].bound;
      end else if (hit1) begin
        look_res.hit         = 1'b1;
        look_res.found_move  = rd_data[1].move;
        look_res.found_score = rd_data[1].score;
        look_res.found_depth = rd_data[1].depth;
        look_res.found_bound = rd_data[1].bound;
      end else begin
        look_res.hit         = 1'b0;
      end
    end

    if (state == ST_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_idx;
      wr_data = '0;
    end else begin
      wr_en   = (state == ST_LOOK) && (op_q == OP_STORE);
      wr_addr = idx_q;
      wr_data = row_next;
    end
  end

  twdp_ram #(
    .DEPTH (CLUSTER_COUNT)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (req_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode_t'(req.opcode);
      tag_q   <= req.key[KEY_W-1:KEY_W-TAG_W];
      idx_q   <= req_idx;
      move_q  <= req.move;
      score_q <= req.score;
      depth_q <= req.search_depth;
      bound_q <= req.bound_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == LAST_IDX) begin
            state       <= ST_IDLE;
            sweep_reply <= 1'b0;
            if (sweep_reply) begin
              out_valid <= 1'b1;
              res       <= '0;
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (opcode_t'(req.opcode) == OP_CLEAR) begin
              state       <= ST_SWEEP;
              sweep_idx   <= '0;
              sweep_reply <= 1'b1;
            end else begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          state     <= ST_IDLE;
          out_valid <= 1'b1;
          res       <= look_res;
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
    end
  end

endmodule

/* sv/twdp_checker.sv */
// port-level checks of the hash table and their binding to the top level
module twdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        hit,
  input logic [15:0] found_move,
  input logic [15:0] found_score,
  input logic [15:0] found_depth,
  input logic [1:0]  found_bound
);

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !hit) |-> (found_move == '0 && found_score == '0
                             && found_depth == '0 && found_bound == '0))
    else $error("miss result carries nonzero fields");

  a_hit_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (hit == (found_bound != '0)))
    else $error("hit and found bound disagree");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item accepted while previous item still in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(hit) && $stable(found_move)
                                   && $stable(found_score) && $stable(found_depth)
                                   && $stable(found_bound)))
    else $error("stalled result changed");

endmodule

bind two_way_depth_preferred_hash_table_unit twdp_checker u_twdp_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .hit         (rsp.hit),
  .found_move  (rsp.found_move),
  .found_score (rsp.found_score),
  .found_depth (rsp.found_depth),
  .found_bound (rsp.found_bound)
);
